>>> hdl/mrd_pkg.sv
// Shared types, constants and lookup functions for the modem response deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mrd_pkg;

  // Longest frame that can be captured, start byte and code included
  localparam int unsigned MAX_FRAME = 28;

  localparam logic [7:0] BYTE_START  = 8'h02;
  localparam logic [7:0] BYTE_REFUSE = 8'h15;
  localparam logic [7:0] UNSOL_FIRST = 8'h50;
  localparam logic [7:0] UNSOL_LAST  = 8'h58;

  // Result status codes
  localparam logic [1:0] ST_FRAME   = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_BADLEAD = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MATCH_CODE   = 1'b0;
  localparam logic CFG_FRAME_LENGTH = 1'b1;

  localparam logic [7:0] MATCH_CODE_RESET   = 8'h50;
  localparam logic [4:0] FRAME_LENGTH_RESET = 5'd11;

  typedef struct packed {
    logic       refused;
    logic       last_of_frame;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
    logic [1:0] status;
  } mrd_result_t;

  // Payload length that follows an unsolicited code 0x50..0x58
  function automatic logic [4:0] unsol_len(input logic [3:0] offs);
    logic [4:0] len;
    case (offs)
      4'd0:    len = 5'd9;
      4'd1:    len = 5'd23;
      4'd2:    len = 5'd2;
      4'd3:    len = 5'd8;
      4'd4:    len = 5'd1;
      4'd5:    len = 5'd0;
      4'd6:    len = 5'd5;
      4'd7:    len = 5'd8;
      4'd8:    len = 5'd1;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Clamp the programmed length into 2..MAX_FRAME
  function automatic logic [4:0] eff_len(input logic [4:0] len);
    logic [4:0] r;
    if (len < 5'd2) begin
      r = 5'd2;
    end else if (len > 5'(MAX_FRAME)) begin
      r = 5'(MAX_FRAME);
    end else begin
      r = len;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mrd_core.sv
// Deframer state machine and configuration registers: one byte per request.
// Depends on mrd_pkg; feeds mrd_outbuf with at most one result per byte.
`default_nettype none

module mrd_core import mrd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_fire,
  input  wire logic [7:0]  in_byte,
  input  wire logic        cfg_fire,
  input  wire logic        cfg_sel,
  input  wire logic [7:0]  cfg_value,
  output logic             res_valid,
  output mrd_result_t      res
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_CODE,
    PH_CAPTURE,
    PH_SKIP
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  skip_left, skip_left_next;
  logic [4:0]  capture_pos, capture_pos_next;
  logic [7:0]  match_code;
  logic [4:0]  frame_length;

  logic [4:0]  cur_pos;
  logic [5:0]  pos_plus;
  logic        is_last;
  logic        is_unsol;
  logic [4:0]  unsol_skip;
  logic [7:0]  unsol_offs;

  // Capture position used by this byte; the code byte is always position 1
  always_comb begin
    cur_pos  = (phase == PH_CODE) ? 5'd1 : capture_pos;
    pos_plus = {1'b0, cur_pos} + 6'd1;
    is_last  = (pos_plus >= {1'b0, eff_len(frame_length)});
    is_unsol   = (in_byte >= UNSOL_FIRST) && (in_byte <= UNSOL_LAST);
    unsol_offs = in_byte - UNSOL_FIRST;
    unsol_skip = unsol_len(unsol_offs[3:0]);
  end

  // Next state and result for the byte on the input
  always_comb begin
    phase_next       = phase;
    skip_left_next   = skip_left;
    capture_pos_next = capture_pos;
    res_valid        = 1'b0;
    res              = '0;
    res.byte_value   = in_byte;

    unique case (phase)
      PH_HUNT: begin
        if (in_byte == BYTE_START) begin
          phase_next = PH_CODE;
        end else begin
          res_valid  = 1'b1;
          res.status = (in_byte == BYTE_REFUSE) ? ST_BUSY : ST_BADLEAD;
        end
      end
      PH_CODE, PH_CAPTURE: begin
        if (phase == PH_CAPTURE || in_byte == match_code) begin
          res_valid         = 1'b1;
          res.status        = ST_FRAME;
          res.byte_index    = cur_pos;
          res.last_of_frame = is_last;
          res.refused       = is_last && (in_byte == BYTE_REFUSE);
          if (is_last) begin
            phase_next       = PH_HUNT;
            capture_pos_next = 5'd0;
          end else begin
            phase_next       = PH_CAPTURE;
            capture_pos_next = pos_plus[4:0];
          end
        end else if (is_unsol) begin
          skip_left_next = unsol_skip;
          phase_next     = (unsol_skip == 5'd0) ? PH_HUNT : PH_SKIP;
        end else begin
          res_valid  = 1'b1;
          res.status = ST_UNKNOWN;
          phase_next = PH_HUNT;
        end
      end
      PH_SKIP: begin
        if (skip_left != 5'd0) begin
          skip_left_next = skip_left - 5'd1;
        end
        if (skip_left <= 5'd1) begin
          phase_next = PH_HUNT;
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      skip_left    <= 5'd0;
      capture_pos  <= 5'd0;
      match_code   <= MATCH_CODE_RESET;
      frame_length <= FRAME_LENGTH_RESET;
    end else begin
      if (in_fire) begin
        phase       <= phase_next;
        skip_left   <= skip_left_next;
        capture_pos <= capture_pos_next;
      end
      if (cfg_fire) begin
        if (cfg_sel == CFG_MATCH_CODE) begin
          match_code <= cfg_value;
        end else begin
          frame_length <= cfg_value[4:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/mrd_outbuf.sv
// Two-entry output stage (result register plus skid register) for results.
// Depends on mrd_pkg for the result type.
`default_nettype none

module mrd_outbuf import mrd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire mrd_result_t push_data,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mrd_result_t      out_data
);

  logic        skid_valid;
  mrd_result_t skid_data;
  logic        pop;

  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;

  // Control: output register refills from skid first, then from the core
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      if (!out_valid) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/modem_response_deframer.sv
// Top level of the modem response deframer: stream ports, core and output stage.
// Depends on mrd_pkg, mrd_core and mrd_outbuf.
//
// Usage:
//   s_* carries received modem bytes (s_tdata[7:0] = rx_byte), one per request.
//   m_* carries results: m_tdata holds byte_value and byte_index, m_tuser
//   holds status and the refusal mark, m_tlast flags the final frame byte.
//   Bytes with no result (start byte, unsolicited code, skipped payload) are just absorbed.
//   cfg_* writes match_code (index 0) or frame_length (index 1); always ready.
// Output: each result is registered in the output stage before it appears on m_*.
// Throughput: one byte per cycle while s_tready is high; the whole state update is
//   one level of logic between the state registers and the result register.
// Stalls: a skid register holds one extra result, so s_tready drops only
//   after a result is held in the skid entry while m_tready stays low.
// Reset: rst (synchronous) returns to hunting for a start byte, empties the
//   output stage and restores match_code = 0x50, frame_length = 11.
`default_nettype none

module modem_response_deframer import mrd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream: [7:0] rx_byte
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  // master stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] byte_value, [12:8] byte_index, [15:13] zero
  output logic [2:0]       m_tuser,   // [1:0] status, [2] refused
  output logic             m_tlast,   // last_of_frame
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic        in_fire;
  logic        res_valid;
  mrd_result_t res;
  mrd_result_t out_res;

  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  mrd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_byte   (s_tdata),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_index),
    .cfg_value (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  mrd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && res_valid),
    .push_data (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  // Pack the result onto the stream fields
  assign m_tdata = {3'b000, out_res.byte_index, out_res.byte_value};
  assign m_tuser = {out_res.refused, out_res.status};
  assign m_tlast = out_res.last_of_frame;

endmodule

`default_nettype wire

>>> hdl/mrd_checker.sv
// Port-level checks for the modem response deframer, bound to the top level.
// Depends on mrd_pkg for status codes and on modem_response_deframer's ports.
`default_nettype none

module mrd_checker import mrd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,
  input  wire logic [2:0]  m_tuser,
  input  wire logic        m_tlast
);

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                && $stable(m_tlast))
    else $error("stalled result changed");

  // Only frame bytes can end a frame
  a_last_is_frame: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tlast |-> m_tuser[1:0] == ST_FRAME)
    else $error("last flag on an error result");

  // Refusal mark only on the final byte
  a_refused_last: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser[2] |-> m_tlast && m_tdata[7:0] == BYTE_REFUSE)
    else $error("refusal mark off the final byte");

  // Error results carry no position
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser[1:0] != ST_FRAME |-> m_tdata[12:8] == 5'd0)
    else $error("error result with nonzero index");

endmodule

bind modem_response_deframer mrd_checker u_mrd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
